### rtl/urr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urr_pkg
// Types and constants shared by the UART receive ring and its checker.
// ---------------------------------------------------------------------------
package urr_pkg;

   typedef enum logic [1:0] {
      MODE_RECEIVE = 2'd0,
      MODE_POP     = 2'd1,
      MODE_FLAGS   = 2'd2,
      MODE_COUNT   = 2'd3
   } mode_type;

   localparam int unsigned FLAG_W      = 5;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned BYTE_W      = 8;

   localparam int unsigned FLAG_PARITY  = 0;
   localparam int unsigned FLAG_FRAMING = 1;
   localparam int unsigned FLAG_NOISE   = 2;
   localparam int unsigned FLAG_OVERRUN = 3;
   localparam int unsigned FLAG_RING_OVF = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      mode_type          mode;
      logic              byte_present;
      logic [BYTE_W-1:0] rx_data;
      logic              parity_error;
      logic              framing_error;
      logic              noise_error;
      logic              overrun_error;
   } req_type;

   typedef struct packed {
      logic               read_valid;
      logic [BYTE_W-1:0]  read_byte;
      logic [FLAG_W-1:0]  error_flags;
      logic [COUNT_W-1:0] overflow_total;
      logic               dropped;
   } rsp_type;

endpackage

### rtl/uart_rx_ring_with_error_flags.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart_rx_ring_with_error_flags
// Receive buffer behind a UART: byte ring with one empty slot, sticky line
// error flags and a saturating dropped-byte counter.
// ---------------------------------------------------------------------------
// One command is taken per clock cycle (busy stays low) and its result shows
// on rsp_valid in the cycle after the transfer, since a pop reads the
// ring memory through its registered read port. The ring holds RING_DEPTH-1
// bytes; a byte arriving on a full ring is dropped and counted. Results
// cannot be held off, so the receiver must take each one in its strobe cycle.
// Ring contents need no clearing after reset: only written slots are popped.
module uart_rx_ring_with_error_flags #(
   parameter int unsigned RING_DEPTH = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  urr_pkg::req_type req_payload,
   output logic            rsp_valid,
   output urr_pkg::rsp_type rsp_payload
);

   localparam int unsigned PTR_W = $clog2(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

   logic [PTR_W-1:0]                 wr_pos_ff, wr_pos_in;
   logic [PTR_W-1:0]                 rd_pos_ff, rd_pos_in;
   logic [urr_pkg::FLAG_W-1:0]       flags_ff, flags_in;
   logic [urr_pkg::COUNT_W-1:0]      count_ff, count_in;

   logic                             rsp_valid_ff;
   logic                             pop_hit_ff, pop_hit_in;
   logic [urr_pkg::FLAG_W-1:0]       flags_out_ff, flags_out_in;
   logic [urr_pkg::COUNT_W-1:0]      total_out_ff, total_out_in;
   logic                             dropped_ff, dropped_in;

   logic                             accept;
   logic [PTR_W-1:0]                 wr_next, rd_next;
   logic                             full, empty;
   logic                             ram_we, ram_re;
   logic [urr_pkg::BYTE_W-1:0]       ram_rdata;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign wr_next = (wr_pos_ff == LAST_POS) ? '0 : wr_pos_ff + 1'b1;
   assign rd_next = (rd_pos_ff == LAST_POS) ? '0 : rd_pos_ff + 1'b1;
   assign full    = (wr_next == rd_pos_ff);
   assign empty   = (rd_pos_ff == wr_pos_ff);

   always_comb begin
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      flags_in     = flags_ff;
      count_in     = count_ff;
      pop_hit_in   = 1'b0;
      flags_out_in = '0;
      total_out_in = '0;
      dropped_in   = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      if (accept) begin
         unique case (req_payload.mode)
            urr_pkg::MODE_RECEIVE: begin
               flags_in[urr_pkg::FLAG_PARITY]  = flags_ff[urr_pkg::FLAG_PARITY]
                                                 | req_payload.parity_error;
               flags_in[urr_pkg::FLAG_FRAMING] = flags_ff[urr_pkg::FLAG_FRAMING]
                                                 | req_payload.framing_error;
               flags_in[urr_pkg::FLAG_NOISE]   = flags_ff[urr_pkg::FLAG_NOISE]
                                                 | req_payload.noise_error;
               flags_in[urr_pkg::FLAG_OVERRUN] = flags_ff[urr_pkg::FLAG_OVERRUN]
                                                 | req_payload.overrun_error;
               if (req_payload.byte_present) begin
                  if (full) begin
                     if (count_ff != urr_pkg::COUNT_MAX) begin
                        count_in = count_ff + 1'b1;
                     end
                     flags_in[urr_pkg::FLAG_RING_OVF] = 1'b1;
                     dropped_in = 1'b1;
                  end else begin
                     ram_we    = 1'b1;
                     wr_pos_in = wr_next;
                  end
               end
            end
            urr_pkg::MODE_POP: begin
               if (!empty) begin
                  ram_re     = 1'b1;
                  pop_hit_in = 1'b1;
                  rd_pos_in  = rd_next;
               end
            end
            urr_pkg::MODE_FLAGS: begin
               flags_out_in = flags_ff;
               flags_in     = '0;
            end
            urr_pkg::MODE_COUNT: begin
               total_out_in = count_ff;
               count_in     = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff    <= '0;
         rd_pos_ff    <= '0;
         flags_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_pos_ff    <= wr_pos_in;
         rd_pos_ff    <= rd_pos_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // result payload, qualified by rsp_valid_ff
   always_ff @(posedge clock) begin
      pop_hit_ff   <= pop_hit_in;
      flags_out_ff <= flags_out_in;
      total_out_ff <= total_out_in;
      dropped_ff   <= dropped_in;
   end

   urr_ram #(
      .WIDTH (urr_pkg::BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_pos_ff),
      .wr_data (req_payload.rx_data),
      .rd_en   (ram_re),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_payload.read_valid     = pop_hit_ff;
   assign rsp_payload.read_byte      = pop_hit_ff ? ram_rdata : '0;
   assign rsp_payload.error_flags    = flags_out_ff;
   assign rsp_payload.overflow_total = total_out_ff;
   assign rsp_payload.dropped        = dropped_ff;

endmodule

### rtl/urr_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module urr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/urr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urr_checker
// Port-level checks for the UART receive ring, bound to the top level.
// ---------------------------------------------------------------------------
module urr_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input urr_pkg::req_type req_payload,
   input logic             rsp_valid,
   input urr_pkg::rsp_type rsp_payload
);

   logic accept;
   assign accept = start & ~busy;

   // every transfer gets exactly one result, in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("no result after a transfer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result without a transfer");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.read_valid) |->
         ($past(req_payload.mode) == urr_pkg::MODE_POP))
      else $error("byte returned for a non-pop command");

   a_drop_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.dropped) |->
         ($past(req_payload.mode) == urr_pkg::MODE_RECEIVE && $past(req_payload.byte_present)))
      else $error("drop reported without a received byte");

   // back-to-back flag reads: the second one sees cleared flags
   a_flags_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.mode == urr_pkg::MODE_FLAGS) ##1
      (accept && req_payload.mode == urr_pkg::MODE_FLAGS) |=>
         (rsp_payload.error_flags == '0))
      else $error("flags not cleared by read");

endmodule

bind uart_rx_ring_with_error_flags urr_checker u_urr_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
